FILE: src/eoi_pkg.sv
// Shared types, constants and the term program for the exact orientation and
// in-sphere block. Used by eoi_mac and the top module; depends on nothing.
package eoi_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_BITS_DEF   = 24;
	localparam int INDEX_W          = 10;
	localparam int LIMB_W           = 32;
	localparam int LCNT_W           = 3;
	localparam int SCR_DEPTH        = 40;
	localparam int SCR_AW           = $clog2(SCR_DEPTH);
	localparam int PC_W             = 6;

	typedef enum logic [1:0] {
		FN_LOAD   = 2'd0,
		FN_PLANE  = 2'd1,
		FN_SPHERE = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	// operand size class: a coordinate difference, a quadratic term, a cubic term
	typedef enum logic [1:0] {
		LC_ONE = 2'd0,
		LC_SQ  = 2'd1,
		LC_CUB = 2'd2
	} lcls_t;

	typedef struct packed {
		logic [SCR_AW-1:0] a_addr;
		logic [SCR_AW-1:0] b_addr;
		lcls_t             la;
		lcls_t             lb;
		logic              sub;
		logic              first;
		logic              wr;
		logic [SCR_AW-1:0] dst;
		logic              last;
	} term_t;

	typedef struct packed {
		logic              go;
		logic              first;
		logic              sub;
		logic [LCNT_W-1:0] la;
		logic [LCNT_W-1:0] lb;
	} mac_cmd_t;

	localparam logic [PC_W-1:0] PLANE_PC0  = PC_W'(0);
	localparam logic [PC_W-1:0] SPHERE_PC0 = PC_W'(9);

	function automatic term_t mk(input int a, input int b, input lcls_t la, input lcls_t lb,
			input logic sub, input logic first, input logic wr, input int dst,
			input logic last);
		term_t t;
		t.a_addr = SCR_AW'(a);
		t.b_addr = SCR_AW'(b);
		t.la     = la;
		t.lb     = lb;
		t.sub    = sub;
		t.first  = first;
		t.wr     = wr;
		t.dst    = SCR_AW'(dst);
		t.last   = last;
		return t;
	endfunction

	// Scratch layout. Plane: row i, axis k at 3i+k; cofactors at 24..26.
	// Sphere: differences at 3i+k, sums at 12+3i+k, lifts at 24+i,
	// xy minors at 28..33, zw minors at 34..39.
	function automatic term_t prog(input logic [PC_W-1:0] pc);
		term_t t;
		unique case (pc)
			6'd0:  t = mk(4, 8, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd1:  t = mk(7, 5, LC_ONE, LC_ONE, 1'b1, 1'b0, 1'b1, 24, 1'b0);
			6'd2:  t = mk(7, 2, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd3:  t = mk(1, 8, LC_ONE, LC_ONE, 1'b1, 1'b0, 1'b1, 25, 1'b0);
			6'd4:  t = mk(1, 5, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd5:  t = mk(4, 2, LC_ONE, LC_ONE, 1'b1, 1'b0, 1'b1, 26, 1'b0);
			6'd6:  t = mk(0, 24, LC_ONE, LC_SQ, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd7:  t = mk(3, 25, LC_ONE, LC_SQ, 1'b0, 1'b0, 1'b0, 0, 1'b0);
			6'd8:  t = mk(6, 26, LC_ONE, LC_SQ, 1'b0, 1'b0, 1'b0, 0, 1'b1);
			// lifts
			6'd9:  t = mk(12, 0, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd10: t = mk(13, 1, LC_ONE, LC_ONE, 1'b0, 1'b0, 1'b0, 0, 1'b0);
			6'd11: t = mk(14, 2, LC_ONE, LC_ONE, 1'b0, 1'b0, 1'b1, 24, 1'b0);
			6'd12: t = mk(15, 3, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd13: t = mk(16, 4, LC_ONE, LC_ONE, 1'b0, 1'b0, 1'b0, 0, 1'b0);
			6'd14: t = mk(17, 5, LC_ONE, LC_ONE, 1'b0, 1'b0, 1'b1, 25, 1'b0);
			6'd15: t = mk(18, 6, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd16: t = mk(19, 7, LC_ONE, LC_ONE, 1'b0, 1'b0, 1'b0, 0, 1'b0);
			6'd17: t = mk(20, 8, LC_ONE, LC_ONE, 1'b0, 1'b0, 1'b1, 26, 1'b0);
			6'd18: t = mk(21, 9, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd19: t = mk(22, 10, LC_ONE, LC_ONE, 1'b0, 1'b0, 1'b0, 0, 1'b0);
			6'd20: t = mk(23, 11, LC_ONE, LC_ONE, 1'b0, 1'b0, 1'b1, 27, 1'b0);
			// xy minors
			6'd21: t = mk(0, 4, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd22: t = mk(3, 1, LC_ONE, LC_ONE, 1'b1, 1'b0, 1'b1, 28, 1'b0);
			6'd23: t = mk(0, 7, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd24: t = mk(6, 1, LC_ONE, LC_ONE, 1'b1, 1'b0, 1'b1, 29, 1'b0);
			6'd25: t = mk(0, 10, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd26: t = mk(9, 1, LC_ONE, LC_ONE, 1'b1, 1'b0, 1'b1, 30, 1'b0);
			6'd27: t = mk(3, 7, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd28: t = mk(6, 4, LC_ONE, LC_ONE, 1'b1, 1'b0, 1'b1, 31, 1'b0);
			6'd29: t = mk(3, 10, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd30: t = mk(9, 4, LC_ONE, LC_ONE, 1'b1, 1'b0, 1'b1, 32, 1'b0);
			6'd31: t = mk(6, 10, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd32: t = mk(9, 7, LC_ONE, LC_ONE, 1'b1, 1'b0, 1'b1, 33, 1'b0);
			// zw minors
			6'd33: t = mk(2, 25, LC_ONE, LC_SQ, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd34: t = mk(5, 24, LC_ONE, LC_SQ, 1'b1, 1'b0, 1'b1, 34, 1'b0);
			6'd35: t = mk(2, 26, LC_ONE, LC_SQ, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd36: t = mk(8, 24, LC_ONE, LC_SQ, 1'b1, 1'b0, 1'b1, 35, 1'b0);
			6'd37: t = mk(2, 27, LC_ONE, LC_SQ, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd38: t = mk(11, 24, LC_ONE, LC_SQ, 1'b1, 1'b0, 1'b1, 36, 1'b0);
			6'd39: t = mk(5, 26, LC_ONE, LC_SQ, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd40: t = mk(8, 25, LC_ONE, LC_SQ, 1'b1, 1'b0, 1'b1, 37, 1'b0);
			6'd41: t = mk(5, 27, LC_ONE, LC_SQ, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd42: t = mk(11, 25, LC_ONE, LC_SQ, 1'b1, 1'b0, 1'b1, 38, 1'b0);
			6'd43: t = mk(8, 27, LC_ONE, LC_SQ, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd44: t = mk(11, 26, LC_ONE, LC_SQ, 1'b1, 1'b0, 1'b1, 39, 1'b0);
			// final expansion
			6'd45: t = mk(28, 39, LC_SQ, LC_CUB, 1'b0, 1'b1, 1'b0, 0, 1'b0);
			6'd46: t = mk(29, 38, LC_SQ, LC_CUB, 1'b1, 1'b0, 1'b0, 0, 1'b0);
			6'd47: t = mk(30, 37, LC_SQ, LC_CUB, 1'b0, 1'b0, 1'b0, 0, 1'b0);
			6'd48: t = mk(31, 36, LC_SQ, LC_CUB, 1'b0, 1'b0, 1'b0, 0, 1'b0);
			6'd49: t = mk(32, 35, LC_SQ, LC_CUB, 1'b1, 1'b0, 1'b0, 0, 1'b0);
			6'd50: t = mk(33, 34, LC_SQ, LC_CUB, 1'b0, 1'b0, 1'b0, 0, 1'b1);
			default: t = mk(0, 0, LC_ONE, LC_ONE, 1'b0, 1'b1, 1'b0, 0, 1'b1);
		endcase
		return t;
	endfunction

endpackage

FILE: src/eoi_ram.sv
// Generic single-port-write RAM with one registered read port.
// Uses no package; instanced for the vertex store and the scratch file.
module eoi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/eoi_mac.sv
// Shared multiply-accumulate unit: one 32x32 limb product a cycle, added into
// a wide accumulator at its limb offset. Depends on eoi_pkg.
module eoi_mac #(
	parameter int ACC_W = 132
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  eoi_pkg::mac_cmd_t    cmd,
	input  logic [ACC_W-1:0]     op_a,
	input  logic [ACC_W-1:0]     op_b,
	output logic [ACC_W-1:0]     acc,
	output logic                 done
);

	localparam int LM = (ACC_W + eoi_pkg::LIMB_W - 1) / eoi_pkg::LIMB_W;
	localparam int MW = LM * eoi_pkg::LIMB_W;
	localparam int LW = eoi_pkg::LIMB_W;

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_ABS  = 4'b0010,
		M_MUL  = 4'b0100,
		M_TAIL = 4'b1000
	} mstate_t;

	mstate_t                     state_q;
	logic [ACC_W-1:0]            a_q, b_q, acc_q;
	logic [MW-1:0]               amag_q, bmag_q;
	logic                        first_q, sub_q, neg_q, pv_q, done_q;
	logic [eoi_pkg::LCNT_W-1:0]  la_q, lb_q, i_q, j_q;
	logic [2*LW-1:0]             pp_q, prod;
	logic [eoi_pkg::LCNT_W:0]    sh_q;
	logic [MW+2*LW-1:0]          placed;
	logic [ACC_W-1:0]            ext;

	assign prod   = amag_q[LW*i_q +: LW] * bmag_q[LW*j_q +: LW];
	assign placed = {{MW{1'b0}}, pp_q} << (LW * sh_q);
	assign ext    = placed[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			pv_q    <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (cmd.go) begin
						state_q <= M_ABS;
					end
				end
				M_ABS: begin
					i_q     <= '0;
					j_q     <= '0;
					state_q <= M_MUL;
				end
				M_MUL: begin
					pv_q <= 1'b1;
					if (j_q == lb_q - 1'b1) begin
						j_q <= '0;
						if (i_q == la_q - 1'b1) begin
							state_q <= M_TAIL;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				M_TAIL: begin
					// last product lands in the accumulator on this edge
					pv_q    <= 1'b0;
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && cmd.go) begin
			a_q     <= op_a;
			b_q     <= op_b;
			first_q <= cmd.first;
			sub_q   <= cmd.sub;
			la_q    <= cmd.la;
			lb_q    <= cmd.lb;
		end
		if (state_q == M_ABS) begin
			amag_q <= a_q[ACC_W-1] ? MW'(-a_q) : MW'(a_q);
			bmag_q <= b_q[ACC_W-1] ? MW'(-b_q) : MW'(b_q);
			neg_q  <= a_q[ACC_W-1] ^ b_q[ACC_W-1] ^ sub_q;
		end
		if (state_q == M_MUL) begin
			pp_q <= prod;
			sh_q <= {1'b0, i_q} + {1'b0, j_q};
		end
		if (state_q == M_ABS && first_q) begin
			acc_q <= '0;
		end else if (pv_q) begin
			acc_q <= neg_q ? acc_q - ext : acc_q + ext;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

FILE: src/exact_orient_insphere_3d.sv
// Exact plane-orientation and in-sphere sign predicates over a vertex store.
// Loads write the store on accept and leave busy low. A query fetches its
// vertices, prepares differences in scratch, then runs each term of its
// program through the one shared 32x32 multiply-accumulate unit, which sets
// its busy time. One query at a time; done is shown for one cycle as busy
// falls, and sign holds from then until the next result. Reset clears
// control only; the vertex store is undefined.
module exact_orient_insphere_3d #(
	parameter int MAX_VERTICES = eoi_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = eoi_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          func,
	input  logic signed [COORD_BITS-1:0]        point_x,
	input  logic signed [COORD_BITS-1:0]        point_y,
	input  logic signed [COORD_BITS-1:0]        point_z,
	input  logic [eoi_pkg::INDEX_W-1:0]         index_a,
	input  logic [eoi_pkg::INDEX_W-1:0]         index_b,
	input  logic [eoi_pkg::INDEX_W-1:0]         index_c,
	input  logic [eoi_pkg::INDEX_W-1:0]         index_d,
	output logic                                done,
	output logic signed [1:0]                   sign
);

	localparam int CB    = COORD_BITS;
	localparam int ACC_W = 5 * CB + 12;
	localparam int L1    = (CB + 1 + 31) / 32;
	localparam int LQ    = (2 * CB + 2 + 31) / 32;
	localparam int LC    = (3 * CB + 4 + 31) / 32;
	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int VW    = 3 * CB;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FETCH = 8'b0000_0010,
		S_FWAIT = 8'b0000_0100,
		S_PREP  = 8'b0000_1000,
		S_RD    = 8'b0001_0000,
		S_GO    = 8'b0010_0000,
		S_WAIT  = 8'b0100_0000,
		S_WB    = 8'b1000_0000
	} state_t;

	state_t                              state_q;
	logic                                sphere_q, rng_q, h_q, done_q;
	logic signed [1:0]                   sign_q;
	logic signed [CB-1:0]                p_q  [3];
	logic signed [CB-1:0]                v0_q [3];
	logic signed [CB-1:0]                v_q  [4][3];
	logic [eoi_pkg::INDEX_W-1:0]         idx_q [4];
	logic [1:0]                          fc_q, i_q, k_q, vlast;
	logic [eoi_pkg::SCR_AW-1:0]          pa_q;
	logic [eoi_pkg::PC_W-1:0]            pc_q;

	logic                                accept, vwe;
	logic [VW-1:0]                       vrd;
	logic [eoi_pkg::INDEX_W-1:0]         fidx;
	eoi_pkg::term_t                      term;
	eoi_pkg::mac_cmd_t                   mcmd;
	logic [ACC_W-1:0]                    sa_rd, sb_rd, mac_acc, swdata;
	logic                                mac_done, swe;
	logic [eoi_pkg::SCR_AW-1:0]          swaddr;
	logic signed [CB-1:0]                opa, opb;
	logic signed [CB:0]                  pval;

	function automatic logic [eoi_pkg::LCNT_W-1:0] lcnt(input eoi_pkg::lcls_t c);
		logic [eoi_pkg::LCNT_W-1:0] n;
		unique case (c)
			eoi_pkg::LC_ONE: n = eoi_pkg::LCNT_W'(L1);
			eoi_pkg::LC_SQ:  n = eoi_pkg::LCNT_W'(LQ);
			eoi_pkg::LC_CUB: n = eoi_pkg::LCNT_W'(LC);
			default:         n = eoi_pkg::LCNT_W'(LC);
		endcase
		return n;
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign vwe    = accept && (func == eoi_pkg::FN_LOAD)
			&& (32'(index_a) < 32'(MAX_VERTICES));
	assign fidx   = idx_q[fc_q];
	assign vlast  = sphere_q ? 2'd3 : 2'd2;
	assign term   = eoi_pkg::prog(pc_q);

	eoi_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vstore (
		.clk   (clk),
		.we    (vwe),
		.waddr (AW'(index_a)),
		.wdata ({point_z, point_y, point_x}),
		.raddr (AW'(fidx)),
		.rdata (vrd)
	);

	// preparation: plane rows against V0, or sphere differences then sums
	always_comb begin
		opa  = (!sphere_q && i_q == 2'd0) ? p_q[k_q] : v_q[i_q][k_q];
		opb  = sphere_q ? p_q[k_q] : v0_q[k_q];
		pval = h_q ? ({opa[CB-1], opa} + {opb[CB-1], opb})
				: ({opa[CB-1], opa} - {opb[CB-1], opb});
	end

	assign swe    = (state_q == S_PREP) || (state_q == S_WB && term.wr);
	assign swaddr = (state_q == S_PREP) ? pa_q : term.dst;
	assign swdata = (state_q == S_PREP) ? ACC_W'(pval) : mac_acc;

	// two copies give two read ports into the scratch file
	eoi_ram #(.WIDTH(ACC_W), .DEPTH(eoi_pkg::SCR_DEPTH)) u_scr_a (
		.clk   (clk),
		.we    (swe),
		.waddr (swaddr),
		.wdata (swdata),
		.raddr (term.a_addr),
		.rdata (sa_rd)
	);

	eoi_ram #(.WIDTH(ACC_W), .DEPTH(eoi_pkg::SCR_DEPTH)) u_scr_b (
		.clk   (clk),
		.we    (swe),
		.waddr (swaddr),
		.wdata (swdata),
		.raddr (term.b_addr),
		.rdata (sb_rd)
	);

	always_comb begin
		mcmd.go    = (state_q == S_GO);
		mcmd.first = term.first;
		mcmd.sub   = term.sub;
		mcmd.la    = lcnt(term.la);
		mcmd.lb    = lcnt(term.lb);
	end

	eoi_mac #(.ACC_W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mcmd),
		.op_a   (sa_rd),
		.op_b   (sb_rd),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			sphere_q <= 1'b0;
			fc_q     <= '0;
			i_q      <= '0;
			k_q      <= '0;
			h_q      <= 1'b0;
			pa_q     <= '0;
			pc_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && func == eoi_pkg::FN_PLANE) begin
						sphere_q <= 1'b0;
						fc_q     <= '0;
						state_q  <= S_FETCH;
					end else if (accept && func == eoi_pkg::FN_SPHERE) begin
						sphere_q <= 1'b1;
						fc_q     <= '0;
						state_q  <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_FWAIT;
				S_FWAIT: begin
					if (fc_q == vlast) begin
						i_q     <= '0;
						k_q     <= '0;
						h_q     <= 1'b0;
						pa_q    <= '0;
						state_q <= S_PREP;
					end else begin
						fc_q    <= fc_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_PREP: begin
					pa_q <= pa_q + 1'b1;
					if (k_q == 2'd2) begin
						k_q <= '0;
						if (i_q == vlast) begin
							i_q <= '0;
							if (sphere_q && !h_q) begin
								h_q <= 1'b1;
							end else begin
								pc_q    <= sphere_q ? eoi_pkg::SPHERE_PC0
										: eoi_pkg::PLANE_PC0;
								state_q <= S_RD;
							end
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_RD: state_q <= S_GO;
				S_GO: state_q <= S_WAIT;
				S_WAIT: begin
					if (mac_done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (term.last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						pc_q    <= pc_q + 1'b1;
						state_q <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q[0]   <= point_x;
			p_q[1]   <= point_y;
			p_q[2]   <= point_z;
			idx_q[0] <= index_a;
			idx_q[1] <= index_b;
			idx_q[2] <= index_c;
			idx_q[3] <= index_d;
		end
		if (state_q == S_FETCH) begin
			rng_q <= (32'(fidx) < 32'(MAX_VERTICES));
		end
		if (state_q == S_FWAIT) begin
			// out-of-store slots read as the origin
			v_q[fc_q][0] <= rng_q ? vrd[CB-1:0]      : '0;
			v_q[fc_q][1] <= rng_q ? vrd[2*CB-1:CB]   : '0;
			v_q[fc_q][2] <= rng_q ? vrd[3*CB-1:2*CB] : '0;
			if (fc_q == 2'd0) begin
				v0_q[0] <= rng_q ? vrd[CB-1:0]      : '0;
				v0_q[1] <= rng_q ? vrd[2*CB-1:CB]   : '0;
				v0_q[2] <= rng_q ? vrd[3*CB-1:2*CB] : '0;
			end
		end
		if (state_q == S_WB && term.last) begin
			sign_q <= mac_acc[ACC_W-1] ? 2'sb11 : ((|mac_acc) ? 2'sb01 : 2'sb00);
		end
	end

	assign done = done_q;
	assign sign = sign_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for exact_orient_insphere_3d: directed table then random loads and queries,
// each sign checked against an exact in-bench predictor. Depends on eoi_pkg and the block.
module tb_top;

	localparam int NV = eoi_pkg::MAX_VERTICES_DEF;
	localparam int CB = eoi_pkg::COORD_BITS_DEF;
	localparam int N_RANDOM = 1430;
	localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

	typedef struct {
		eoi_pkg::func_t fn;
		logic [CB-1:0] px, py, pz;
		logic [9:0]    ia, ib, ic, id;
		bit            known;
		logic signed [1:0] sgn;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic [1:0] func = eoi_pkg::FN_LOAD;
	logic signed [CB-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic [eoi_pkg::INDEX_W-1:0] index_a = '0, index_b = '0, index_c = '0, index_d = '0;
	logic signed [1:0] sign;

	logic signed [CB-1:0] vx [NV], vy [NV], vz [NV];
	bit written [NV];
	logic signed [1:0] sign_queue [$];
	int errors = 0, n_plane = 0, n_sphere = 0, n_load = 0, n_zero = 0;

	exact_orient_insphere_3d DUT (.*);

	initial forever #1 clk = ~clk;

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic signed [1:0] sgn_of(input logic signed [255:0] v);
		return (v < 0) ? -2'sd1 : (v == 0) ? 2'sd0 : 2'sd1;
	endfunction

	function automatic logic signed [255:0] at(input logic [9:0] i, input int k);
		if (i >= NV)
			return '0;
		case (k)
			0: return vx[i];
			1: return vy[i];
			default: return vz[i];
		endcase
	endfunction

	function automatic logic signed [1:0] orient_sign(input row_t r);
		logic signed [255:0] p [3], a [3], b [3], c [3];
		logic [9:0] ix [3];
		ix = '{r.ia, r.ib, r.ic};
		p = '{256'(signed'(r.px)), 256'(signed'(r.py)), 256'(signed'(r.pz))};
		for (int k = 0; k < 3; k++) begin
			a[k] = p[k] - at(ix[0], k);
			b[k] = at(ix[1], k) - at(ix[0], k);
			c[k] = at(ix[2], k) - at(ix[0], k);
		end
		return sgn_of(a[0] * (b[1] * c[2] - b[2] * c[1])
			- a[1] * (b[0] * c[2] - b[2] * c[0])
			+ a[2] * (b[0] * c[1] - b[1] * c[0]));
	endfunction

	function automatic logic signed [1:0] sphere_sign(input row_t r);
		logic signed [255:0] p [3], m [4][4], d;
		logic [9:0] ix [4];
		ix = '{r.ia, r.ib, r.ic, r.id};
		p = '{256'(signed'(r.px)), 256'(signed'(r.py)), 256'(signed'(r.pz))};
		for (int i = 0; i < 4; i++) begin
			m[i][3] = '0;
			for (int k = 0; k < 3; k++) begin
				m[i][k] = at(ix[i], k) - p[k];
				m[i][3] += (at(ix[i], k) + p[k]) * m[i][k];
			end
		end
		// Laplace expansion on 2x2 minors of columns (0,1) and (2,3)
		d = (m[0][0]*m[1][1]-m[1][0]*m[0][1]) * (m[2][2]*m[3][3]-m[3][2]*m[2][3])
			- (m[0][0]*m[2][1]-m[2][0]*m[0][1]) * (m[1][2]*m[3][3]-m[3][2]*m[1][3])
			+ (m[0][0]*m[3][1]-m[3][0]*m[0][1]) * (m[1][2]*m[2][3]-m[2][2]*m[1][3])
			+ (m[1][0]*m[2][1]-m[2][0]*m[1][1]) * (m[0][2]*m[3][3]-m[3][2]*m[0][3])
			- (m[1][0]*m[3][1]-m[3][0]*m[1][1]) * (m[0][2]*m[2][3]-m[2][2]*m[0][3])
			+ (m[2][0]*m[3][1]-m[3][0]*m[2][1]) * (m[0][2]*m[1][3]-m[1][2]*m[0][3]);
		return sgn_of(d);
	endfunction

	// start stays high into the next item when there is no gap; drop it only for a gap
	task automatic send(input row_t r);
		logic signed [1:0] s;
		int gap;
		gap = $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= r.fn;
		point_x <= r.px; point_y <= r.py; point_z <= r.pz;
		index_a <= r.ia; index_b <= r.ib; index_c <= r.ic; index_d <= r.id;
		do @(posedge clk); while (busy);
		case (r.fn)
			eoi_pkg::FN_LOAD: begin
				n_load++;
				if (r.ia < NV) begin
					vx[r.ia] = r.px; vy[r.ia] = r.py; vz[r.ia] = r.pz;
					written[r.ia] = 1'b1;
				end
			end
			eoi_pkg::FN_PLANE, eoi_pkg::FN_SPHERE: begin
				s = (r.fn == eoi_pkg::FN_PLANE) ? orient_sign(r) : sphere_sign(r);
				if (r.known && s !== r.sgn) begin
					$error("sign: expected %0d (table), predictor %0d", r.sgn, s);
					errors++;
				end
				if (r.fn == eoi_pkg::FN_PLANE) n_plane++; else n_sphere++;
				if (s == 0) n_zero++;
				sign_queue.push_back(r.known ? r.sgn : s);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sign_queue.size() == 0) begin
				$error("sign result with no query outstanding");
				errors++;
			end else if (sign !== sign_queue[0]) begin
				$error("sign: expected %0d, actual %0d", sign_queue[0], sign);
				errors++;
				void'(sign_queue.pop_front());
			end else
				void'(sign_queue.pop_front());
		end
	end

	function automatic row_t mkrow(input eoi_pkg::func_t f, input logic [CB-1:0] x, y, z,
			input int a, b, c, d, input bit k = 0, input logic signed [1:0] s = 0);
		row_t r;
		r = '{f, x, y, z, 10'(a), 10'(b), 10'(c), 10'(d), k, s};
		return r;
	endfunction

	function automatic logic [CB-1:0] rcoord(input int mode);
		case (mode)
			0: return CB'($urandom);
			1: return CB'($urandom_range(0, 16)) - CB'(8);
			2: return ($urandom_range(0, 1)) ? CMAX : CMIN;
			default: return CB'($urandom_range(0, 2000)) - CB'(1000);
		endcase
	endfunction

	// queries draw only from loaded slots
	function automatic int rslot(input bit any);
		int s;
		if (any)
			return $urandom_range(0, NV - 1);
		do s = $urandom_range(0, NV - 1); while (!written[s]);
		return s;
	endfunction

	initial begin
		row_t dir [$];
		row_t r;
		int m;
		// unit tetrahedron, extremes, a no-op function code, coplanar cases
		dir = '{
			mkrow(eoi_pkg::FN_LOAD, 0, 0, 0, 0, 0, 0, 0),
			mkrow(eoi_pkg::FN_LOAD, 1, 0, 0, 1, 0, 0, 0),
			mkrow(eoi_pkg::FN_LOAD, 0, 1, 0, 2, 0, 0, 0),
			mkrow(eoi_pkg::FN_LOAD, 0, 0, 1, 3, 0, 0, 0),
			mkrow(eoi_pkg::FN_PLANE, 0, 0, 1, 0, 1, 2, 0, 1, 2'sd1),
			mkrow(eoi_pkg::FN_PLANE, 0, 0, CB'(-1), 0, 1, 2, 0, 1, -2'sd1),
			mkrow(eoi_pkg::FN_PLANE, 5, 7, 0, 0, 1, 2, 0, 1, 2'sd0),
			mkrow(eoi_pkg::FN_PLANE, 3, 3, 3, 0, 0, 2, 0, 1, 2'sd0),
			mkrow(eoi_pkg::FN_SPHERE, 0, 0, 0, 0, 1, 2, 3),
			mkrow(eoi_pkg::FN_SPHERE, CMAX, CMAX, CMAX, 0, 1, 2, 3),
			mkrow(eoi_pkg::FN_SPHERE, 1, 0, 0, 0, 1, 2, 3, 1, 2'sd0),
			mkrow(eoi_pkg::FN_LOAD, CMAX, CMIN, CMAX, 1023, 0, 0, 0),
			mkrow(eoi_pkg::FN_LOAD, CMIN, CMAX, CMIN, 1022, 0, 0, 0),
			mkrow(eoi_pkg::FN_LOAD, CMIN, CMIN, CMIN, 1021, 0, 0, 0),
			mkrow(eoi_pkg::FN_PLANE, CMAX, CMAX, CMAX, 1023, 1022, 1021, 0),
			mkrow(eoi_pkg::FN_PLANE, CMIN, CMIN, CMAX, 1021, 1022, 1023, 0),
			mkrow(eoi_pkg::FN_SPHERE, CMIN, CMAX, CMIN, 1023, 1022, 1021, 0),
			mkrow(eoi_pkg::FN_SPHERE, CMAX, CMIN, CMIN, 1021, 1023, 1022, 3),
			mkrow(eoi_pkg::FN_NONE, CMAX, CMAX, CMAX, 1023, 1023, 1023, 1023),
			mkrow(eoi_pkg::FN_PLANE, 0, 0, 0, 1023, 1023, 1022, 0, 1, 2'sd0)
		};
		for (int i = 0; i < NV; i++) begin
			vx[i] = '0; vy[i] = '0; vz[i] = '0; written[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i]) send(dir[i]);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				// hold off until every query in flight has answered
				start <= 1'b0;
				do @(posedge clk); while (sign_queue.size() != 0);
			end
			m = $urandom_range(0, 3);
			r.known = 0; r.sgn = 0;
			r.px = rcoord(m); r.py = rcoord(m); r.pz = rcoord(m);
			case ($urandom_range(0, 9))
				0, 1, 2: r.fn = eoi_pkg::FN_LOAD;
				3, 4, 5: r.fn = eoi_pkg::FN_PLANE;
				6, 7, 8: r.fn = eoi_pkg::FN_SPHERE;
				default: r.fn = eoi_pkg::FN_NONE;
			endcase
			if (r.fn == eoi_pkg::FN_LOAD || r.fn == eoi_pkg::FN_NONE) begin
				r.ia = rslot(1); r.ib = rslot(1); r.ic = rslot(1); r.id = rslot(1);
			end else begin
				r.ia = rslot(0); r.ib = rslot(0); r.ic = rslot(0); r.id = rslot(0);
				// coincident vertices hit the zero case
				if ($urandom_range(0, 9) == 0) r.ib = r.ia;
			end
			send(r);
		end
		start <= 1'b0;
		do @(posedge clk); while (sign_queue.size() != 0);
		repeat (400) @(posedge clk);
		$display("covered %0d loads, %0d plane and %0d sphere queries (%0d zero signs)",
			n_load, n_plane, n_sphere, n_zero);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
